@@ rtl/csf_pkg.sv @@
package csf_pkg;

    localparam int DELAY_DEPTH = 32;
    localparam int LINE_LEN    = DELAY_DEPTH - 1;
    localparam int HALF_TAPS   = (LINE_LEN - 1) / 2;
    localparam int CENTRE_IDX  = HALF_TAPS;
    localparam int NUM_TERMS   = HALF_TAPS + 1;

    localparam logic signed [15:0] CENTRE_COEF = 16'sd9245;

    localparam logic signed [15:0] PAIR_COEF [HALF_TAPS] = '{
        -16'sd22,   16'sd184,   16'sd295,   -16'sd507,
        -16'sd1150, 16'sd571,   16'sd2672,  16'sd261,
        -16'sd4361, -16'sd2383, 16'sd5214,  16'sd5406,
        -16'sd4339, -16'sd8139, 16'sd1696
    };

    typedef struct packed {
        logic signed [15:0] im;
        logic signed [15:0] re;
    } t_sample;

    typedef logic [15:0] t_term;

    typedef struct packed {
        logic adv;
        logic take;
    } t_pipe_ctl;

endpackage

@@ rtl/csf_if.sv @@
interface csf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;

    modport source (output valid, output sample_real, output sample_imag, input ready);
    modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface csf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_real;
    logic signed [16:0] out_imag;

    modport source (output valid, output out_real, output out_imag, input ready);
    modport sink   (input valid, input out_real, input out_imag, output ready);
endinterface

@@ rtl/csf_delay_line.sv @@
module csf_delay_line
    import csf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_sample   i_sample,
    output t_sample   o_line [LINE_LEN],
    output logic      o_valid
);

    t_sample r_line [LINE_LEN];
    logic    r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINE_LEN; k++) begin
                r_line[k] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.take) begin
                for (int k = 0; k < LINE_LEN - 1; k++) begin
                    r_line[k] <= r_line[k + 1];
                end
                r_line[LINE_LEN - 1] <= i_sample;
            end
            if (i_ctl.adv) begin
                r_valid <= i_ctl.take;
            end
        end
    end

    assign o_line  = r_line;
    assign o_valid = r_valid;

endmodule

@@ rtl/csf_tap_mult.sv @@
module csf_tap_mult
    import csf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  logic      i_valid,
    input  t_sample   i_line [LINE_LEN],
    output t_term     o_term_re [NUM_TERMS],
    output t_term     o_term_im [NUM_TERMS],
    output logic      o_valid
);

    t_term r_term_re [NUM_TERMS];
    t_term r_term_im [NUM_TERMS];
    t_term n_term_re [NUM_TERMS];
    t_term n_term_im [NUM_TERMS];
    logic  r_valid;

    // term = (product >>> 15) truncated to 16 bits = product[30:15]
    always_comb begin
        logic signed [16:0] s_re;
        logic signed [16:0] s_im;
        logic signed [32:0] p_re;
        logic signed [32:0] p_im;
        for (int i = 0; i < HALF_TAPS; i++) begin
            s_re = 17'(i_line[i].re) + 17'(i_line[LINE_LEN - 1 - i].re);
            s_im = 17'(i_line[i].im) + 17'(i_line[LINE_LEN - 1 - i].im);
            p_re = 33'(s_re) * 33'(PAIR_COEF[i]);
            p_im = 33'(s_im) * 33'(PAIR_COEF[i]);
            n_term_re[i] = p_re[30:15];
            n_term_im[i] = p_im[30:15];
        end
        p_re = 33'(i_line[CENTRE_IDX].re) * 33'(CENTRE_COEF);
        p_im = 33'(i_line[CENTRE_IDX].im) * 33'(CENTRE_COEF);
        n_term_re[HALF_TAPS] = p_re[30:15];
        n_term_im[HALF_TAPS] = p_im[30:15];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_term_re <= n_term_re;
            r_term_im <= n_term_im;
        end
    end

    assign o_term_re = r_term_re;
    assign o_term_im = r_term_im;
    assign o_valid   = r_valid;

endmodule

@@ rtl/csf_accum.sv @@
module csf_accum
    import csf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_ctl          i_ctl,
    input  logic               i_valid,
    input  t_term              i_term_re [NUM_TERMS],
    input  t_term              i_term_im [NUM_TERMS],
    output logic               o_valid,
    output logic signed [15:0] o_real,
    output logic signed [16:0] o_imag
);

    logic        r_valid;
    logic [15:0] r_real;
    logic [16:0] r_imag;
    logic [15:0] n_real;
    logic [16:0] n_imag;

    // adder tree, wraps mod 2^16; the imaginary sum is then negated into 17 bits
    always_comb begin
        t_term l1_re [8];
        t_term l1_im [8];
        t_term l2_re [4];
        t_term l2_im [4];
        t_term l3_re [2];
        t_term l3_im [2];
        t_term acc_im;
        for (int k = 0; k < 8; k++) begin
            l1_re[k] = i_term_re[2 * k] + i_term_re[2 * k + 1];
            l1_im[k] = i_term_im[2 * k] + i_term_im[2 * k + 1];
        end
        for (int k = 0; k < 4; k++) begin
            l2_re[k] = l1_re[2 * k] + l1_re[2 * k + 1];
            l2_im[k] = l1_im[2 * k] + l1_im[2 * k + 1];
        end
        for (int k = 0; k < 2; k++) begin
            l3_re[k] = l2_re[2 * k] + l2_re[2 * k + 1];
            l3_im[k] = l2_im[2 * k] + l2_im[2 * k + 1];
        end
        n_real = l3_re[0] + l3_re[1];
        acc_im = l3_im[0] + l3_im[1];
        n_imag = 17'd0 - {acc_im[15], acc_im};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_real <= n_real;
            r_imag <= n_imag;
        end
    end

    assign o_valid = r_valid;
    assign o_real  = r_real;
    assign o_imag  = r_imag;

endmodule

@@ rtl/complex_symmetric_fir_q15.sv @@
// channel  dir  fields                    handshake
// i_in     in   sample_real, sample_imag  valid/ready
// o_out    out  out_real, out_imag        valid/ready
//
// One word accepted per cycle while the output register is empty or taken; the
// accepting edge loads the delay line, and later advancing edges load the
// product and sum registers in turn; the sum register holds the valid result.
// All stages advance together whenever the output register is empty or taken.
// Synchronous active-low reset clears the delay line and all valid flags.
// A stalled output holds its word and blocks intake until taken.
module complex_symmetric_fir_q15
    import csf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    csf_in_if.sink   i_in,
    csf_out_if.source o_out
);

    t_pipe_ctl w_ctl;
    t_sample   w_sample;
    t_sample   w_line [LINE_LEN];
    logic      w_line_valid;
    t_term     w_term_re [NUM_TERMS];
    t_term     w_term_im [NUM_TERMS];
    logic      w_term_valid;
    logic      w_out_valid;

    assign w_ctl.adv  = !w_out_valid || o_out.ready;
    assign w_ctl.take = i_in.valid && w_ctl.adv;
    assign i_in.ready = w_ctl.adv;

    assign w_sample.re = i_in.sample_real;
    assign w_sample.im = i_in.sample_imag;

    csf_delay_line u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (w_sample),
        .o_line   (w_line),
        .o_valid  (w_line_valid)
    );

    csf_tap_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_valid   (w_line_valid),
        .i_line    (w_line),
        .o_term_re (w_term_re),
        .o_term_im (w_term_im),
        .o_valid   (w_term_valid)
    );

    csf_accum u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_valid   (w_term_valid),
        .i_term_re (w_term_re),
        .i_term_im (w_term_im),
        .o_valid   (w_out_valid),
        .o_real    (o_out.out_real),
        .o_imag    (o_out.out_imag)
    );

    assign o_out.valid = w_out_valid;

endmodule

@@ rtl/csf_checker.sv @@
module csf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_real,
    input logic [16:0] i_out_imag
);

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output register state");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !(i_in_valid && i_in_ready) ##1
        !i_out_valid && !(i_in_valid && i_in_ready) ##1 !i_out_valid |=> !i_out_valid)
        else $error("output word without an accepted input word");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        i_out_valid && $stable(i_out_real) && $stable(i_out_imag))
        else $error("stalled output word changed");

endmodule

bind complex_symmetric_fir_q15 csf_checker u_csf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_real  (o_out.out_real),
    .i_out_imag  (o_out.out_imag)
);
